>>> sv/skyra_pkg.sv
`timescale 1ns / 1ps
package skyra_pkg;

  // Sequencer state codes.
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // Operation codes of the input item.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Width of position sums (column index plus width plus one, page size at most 256).
  localparam int SUM_W = 10;

  typedef logic [2:0] state_t;

  // One result item.
  typedef struct packed {
    logic [6:0] page_index;
    logic [6:0] x_pos;
    logic [6:0] y_pos;
    logic       full_res;
  } result_t;

endpackage

>>> sv/skyline_rect_allocator.sv
`timescale 1ns / 1ps
// Skyline rectangle allocator.
// Input channel (in_valid/in_ready) carries one item: an operation, a width and a
// height. Operation allocate returns the page, x and y of the placed rectangle, or
// full_res when no page holds it. Operation clear zeroes every skyline.
// Result channel (out_valid/out_ready) returns exactly one result item per input item.
// The skyline heights live in one memory of NUM_PAGES*PAGE_SIZE entries with one
// read and one write port; a single compare unit walks it under a small sequencer.
// Allocate: per page, every window position reads each of its columns and compares it
// (ST_RD, then ST_CMP), stopping a window early at the first column that is not below
// the best height so far; a placement then writes the w columns of the window.
// Clear writes one entry per cycle until every entry of the memory is zero.
// After reset the same clearing pass runs with in_ready low.
// One item is worked on at a time; in_ready is high only while the sequencer idles.
// A finished result waits in the output register while the next item is accepted;
// if the receiver still stalls when that item is done, the sequencer holds it.
module skyline_rect_allocator #(
  parameter int NUM_PAGES = 96,
  parameter int PAGE_SIZE = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_rect_width,
  input  logic [7:0] in_rect_height,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_page_index,
  output logic [6:0] out_x_pos,
  output logic [6:0] out_y_pos,
  output logic       out_full_res
);
  import skyra_pkg::*;

  localparam int DEPTH = NUM_PAGES * PAGE_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW    = $clog2(PAGE_SIZE + 1);
  localparam int CW    = $clog2(PAGE_SIZE);
  localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            clr_op_r, clr_op_nxt;
  logic [PW-1:0]   page_r, page_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [HW-1:0]   best_r, best_nxt;
  logic [HW-1:0]   top_r, top_nxt;
  logic            found_r, found_nxt;
  logic [CW-1:0]   bx_r, bx_nxt;
  logic [HW-1:0]   by_r, by_nxt;
  logic [7:0]      w_r, w_nxt;
  logic [7:0]      h_r, h_nxt;
  result_t         res_r, res_nxt;
  result_t         out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Skyline memory.
  logic [HW-1:0]   mem [DEPTH];
  logic [HW-1:0]   rdata_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [HW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Helper values for the scan.
  logic [HW-1:0]    top_max;
  logic [SUM_W-1:0] next_end;
  logic [SUM_W-1:0] place_top;
  logic [15:0]      page_ext;
  logic [15:0]      bx_ext;
  logic [15:0]      by_ext;
  logic             out_free;

  assign top_max   = (rdata_r > top_r) ? rdata_r : top_r;
  assign next_end  = SUM_W'(i_r) + SUM_W'(1) + SUM_W'(w_r);
  assign place_top = SUM_W'(by_r) + SUM_W'(h_r);
  assign page_ext  = 16'(page_r);
  assign bx_ext    = 16'(bx_r);
  assign by_ext    = 16'(by_r);
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_page_index = out_r.page_index;
  assign out_x_pos      = out_r.x_pos;
  assign out_y_pos      = out_r.y_pos;
  assign out_full_res   = out_r.full_res;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_op_nxt    = clr_op_r;
    page_nxt      = page_r;
    base_nxt      = base_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    best_nxt      = best_r;
    top_nxt       = top_r;
    found_nxt     = found_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = base_r + AW'(bx_r) + AW'(j_r);
    mem_wdata     = place_top[HW-1:0];
    mem_raddr     = base_r + AW'(i_r) + AW'(j_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_addr_nxt = '0;
          if (clr_op_r) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          w_nxt    = in_rect_width;
          h_nxt    = in_rect_height;
          page_nxt = '0;
          base_nxt = '0;
          i_nxt    = '0;
          j_nxt    = '0;
          best_nxt = HW'(PAGE_SIZE);
          top_nxt  = '0;
          found_nxt = 1'b0;
          if (in_operation == OP_CLEAR) begin
            clr_op_nxt   = 1'b1;
            clr_addr_nxt = '0;
            state_nxt    = ST_CLR;
          end else if (in_rect_width == 8'd0 ||
                       SUM_W'(in_rect_width) >= SUM_W'(PAGE_SIZE)) begin
            // Zero width or no window position: refused.
            res_nxt          = '0;
            res_nxt.full_res = 1'b1;
            state_nxt        = ST_DONE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rdata_r >= best_r || SUM_W'(j_r) + SUM_W'(1) == SUM_W'(w_r)) begin
          // Window closes: either it failed or all its columns are below best.
          if (rdata_r < best_r) begin
            best_nxt  = top_max;
            bx_nxt    = i_r;
            by_nxt    = top_max;
            found_nxt = 1'b1;
          end
          j_nxt   = '0;
          top_nxt = '0;
          if (next_end < SUM_W'(PAGE_SIZE)) begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_CHK;
          end
        end else begin
          top_nxt   = top_max;
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_CHK: begin
        j_nxt = '0;
        if (found_r && place_top <= SUM_W'(PAGE_SIZE)) begin
          state_nxt = ST_WR;
        end else if (32'(page_r) + 1 < NUM_PAGES) begin
          page_nxt  = page_r + PW'(1);
          base_nxt  = base_r + AW'(PAGE_SIZE);
          i_nxt     = '0;
          best_nxt  = HW'(PAGE_SIZE);
          top_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_RD;
        end else begin
          res_nxt          = '0;
          res_nxt.full_res = 1'b1;
          state_nxt        = ST_DONE;
        end
      end
      ST_WR: begin
        mem_we = 1'b1;
        j_nxt  = j_r + CW'(1);
        if (SUM_W'(j_r) + SUM_W'(1) == SUM_W'(w_r)) begin
          res_nxt.page_index = page_ext[6:0];
          res_nxt.x_pos      = bx_ext[6:0];
          res_nxt.y_pos      = by_ext[6:0];
          res_nxt.full_res   = 1'b0;
          state_nxt          = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          clr_op_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    base_r  <= base_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    best_r  <= best_nxt;
    top_r   <= top_nxt;
    found_r <= found_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import skyra_pkg::*;

  localparam int PAGES = 96;
  localparam int SIDE  = 128;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [7:0] in_rect_width;
  logic [7:0] in_rect_height;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_page_index;
  logic [6:0] out_x_pos;
  logic [6:0] out_y_pos;
  logic       out_full_res;

  skyline_rect_allocator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_page_index (out_page_index),
    .out_x_pos      (out_x_pos),
    .out_y_pos      (out_y_pos),
    .out_full_res   (out_full_res)
  );

  // One row of the directed stimulus table.
  typedef struct {
    logic       op;
    logic [7:0] w;
    logic [7:0] h;
    bit         typed;
    result_t    res;
  } stim_row_t;

  int        skyline [PAGES][SIDE];
  result_t   placements_due [$];
  stim_row_t stim_table [$];
  int        error_count = 0;
  int        rx_wait = 0;
  int        rx_seen = 0;
  int        rx_seen_last = 0;
  int        tx_gap_max;
  int        rx_gap_max;
  bit        row_typed;
  result_t   row_res;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch: %s", msg);
    error_count++;
  endtask

  // Zero every skyline in the local copy.
  function automatic void wipe_skylines();
    for (int p = 0; p < PAGES; p++)
      for (int c = 0; c < SIDE; c++)
        skyline[p][c] = 0;
  endfunction

  // Work out the placement of one item and update the local skylines.
  function automatic result_t place_rect(input logic op, input logic [7:0] w8,
                                         input logic [7:0] h8);
    result_t r;
    int w;
    int h;
    int best;
    int top;
    int hv;
    int bx;
    int by;
    bit found;
    bit ok;
    r = '0;
    w = w8;
    h = h8;
    if (op == OP_CLEAR) begin
      wipe_skylines();
      return r;
    end
    if (w == 0) begin
      r.full_res = 1'b1;
      return r;
    end
    for (int p = 0; p < PAGES; p++) begin
      best = SIDE;
      found = 0;
      bx = 0;
      by = 0;
      for (int i = 0; i + w < SIDE; i++) begin
        top = 0;
        ok = 1;
        for (int j = 0; j < w; j++) begin
          hv = skyline[p][i + j];
          if (hv >= best) begin
            ok = 0;
            break;
          end
          if (hv > top) top = hv;
        end
        if (ok) begin
          best = top;
          bx = i;
          by = top;
          found = 1;
        end
      end
      if (found && by + h <= SIDE) begin
        for (int i = 0; i < w; i++) skyline[p][bx + i] = by + h;
        r.page_index = p[6:0];
        r.x_pos = bx[6:0];
        r.y_pos = by[6:0];
        return r;
      end
    end
    r.full_res = 1'b1;
    return r;
  endfunction

  task automatic add_row(input logic op, input int w, input int h, input bit typed,
                         input int pg, input int x, input int y, input bit full);
    stim_row_t row;
    row.op = op;
    row.w = w[7:0];
    row.h = h[7:0];
    row.typed = typed;
    row.res.page_index = pg[6:0];
    row.res.x_pos = x[6:0];
    row.res.y_pos = y[6:0];
    row.res.full_res = full;
    stim_table.push_back(row);
  endtask

  // Offer one item after a random gap and hold it until accepted.
  task automatic send_item(input logic op, input logic [7:0] w, input logic [7:0] h);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_rect_width <= w;
    in_rect_height <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  // Predict on every accepted item and check every accepted result.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (row_typed) begin
        void'(place_rect(in_operation, in_rect_width, in_rect_height));
        placements_due.push_back(row_res);
      end else begin
        placements_due.push_back(place_rect(in_operation, in_rect_width, in_rect_height));
      end
    end
    if (rst_n && out_valid && out_ready) begin
      rx_seen <= rx_seen + 1;
      if (placements_due.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        result_t e;
        e = placements_due.pop_front();
        if (out_page_index !== e.page_index)
          report_mismatch($sformatf("page_index %0d, expected %0d", out_page_index,
                                    e.page_index));
        if (out_x_pos !== e.x_pos)
          report_mismatch($sformatf("x_pos %0d, expected %0d", out_x_pos, e.x_pos));
        if (out_y_pos !== e.y_pos)
          report_mismatch($sformatf("y_pos %0d, expected %0d", out_y_pos, e.y_pos));
        if (out_full_res !== e.full_res)
          report_mismatch($sformatf("full_res %0b, expected %0b", out_full_res,
                                    e.full_res));
      end
    end
  end

  // Receiver stall: draws a wait after each result item and counts it down.
  always @(negedge clk) begin
    int wait_now;
    wait_now = rx_wait;
    if (rx_seen != rx_seen_last) begin
      wait_now = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
      rx_seen_last <= rx_seen;
    end
    out_ready <= (wait_now == 0);
    rx_wait <= (wait_now > 0) ? wait_now - 1 : 0;
  end

  // Run limit.
  initial begin
    #(1_000_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic       op;
    logic [7:0] w;
    logic [7:0] h;
    int         pick;
    int         waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_ALLOC;
    in_rect_width = 8'd0;
    in_rect_height = 8'd0;
    tx_gap_max = 15;
    rx_gap_max = 15;
    row_typed = 0;
    row_res = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, both operations and the refused requests.
    add_row(OP_ALLOC, 1, 1, 1, 0, 0, 0, 0);
    add_row(OP_ALLOC, 0, 5, 1, 0, 0, 0, 1);
    add_row(OP_ALLOC, 0, 255, 1, 0, 0, 0, 1);
    add_row(OP_ALLOC, 128, 1, 1, 0, 0, 0, 1);
    add_row(OP_ALLOC, 255, 255, 1, 0, 0, 0, 1);
    add_row(OP_ALLOC, 127, 1, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 1, 129, 1, 0, 0, 0, 1);
    add_row(OP_ALLOC, 3, 255, 1, 0, 0, 0, 1);
    add_row(OP_CLEAR, 255, 255, 1, 0, 0, 0, 0);
    add_row(OP_ALLOC, 126, 128, 1, 0, 0, 0, 0);
    add_row(OP_ALLOC, 1, 128, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 2, 0, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 64, 128, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 5, 7, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 5, 3, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 10, 120, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 17, 85, 0, 0, 0, 0, 0);
    add_row(OP_CLEAR, 0, 0, 1, 0, 0, 0, 0);
    add_row(OP_ALLOC, 120, 64, 1, 0, 0, 0, 0);
    add_row(OP_ALLOC, 7, 64, 0, 0, 0, 0, 0);
    add_row(OP_ALLOC, 8, 64, 0, 0, 0, 0, 0);
    foreach (stim_table[k]) begin
      @(negedge clk);
      in_valid <= 1'b0;
      row_typed = stim_table[k].typed;
      row_res = stim_table[k].res;
      send_item(stim_table[k].op, stim_table[k].w, stim_table[k].h);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    row_typed = 0;

    // Random items, mostly small rectangles so pages fill slowly.
    for (int n = 0; n < 2000; n++) begin
      if (n % 200 == 0) begin
        tx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 15;
        rx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 15;
      end
      // Hold off once until the block has drained.
      if (n == 1000) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge clk);
      end
      op = ($urandom_range(99, 0) == 0) ? OP_CLEAR : OP_ALLOC;
      pick = $urandom_range(99, 0);
      if (pick < 90) w = $urandom_range(24, 1);
      else if (pick < 96) w = $urandom_range(127, 25);
      else if (pick < 98) w = $urandom_range(255, 128);
      else w = 8'd0;
      pick = $urandom_range(199, 0);
      if (pick < 190) h = $urandom_range(32, 0);
      else if (pick < 199) h = $urandom_range(128, 33);
      else h = $urandom_range(255, 129);
      send_item(op, w, h);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then keep watching for stray results before the verdict.
    waited = 0;
    while (placements_due.size() != 0 && waited < 5_000_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (error_count == 0 && placements_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
